// ===== hw/rtl/tga_pkg.sv =====
// Shared types and constants for the Targa run-length row encoder.
package tga_pkg;

    localparam int CNT_W   = 8;
    localparam int PIX_W   = 32;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam logic [7:0] RUN_FLAG = 8'h80;

    typedef struct packed {
        logic [7:0]       hdr;
        logic [CNT_W-1:0] n_ram;
        logic             bank;
        logic             tail;
        logic [PIX_W-1:0] tail_pix;
        logic             eor;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } rel_t;

endpackage

// ===== hw/rtl/tga_rle_row_encoder.sv =====
// Top level of the Targa run-length row encoder.
// Pixels enter one per cycle while the packet queue has two free slots and the
// raw-store bank of the open raw packet is not still being read out; a raw
// packet is stored in one of two banks, so a new raw packet can fill while the
// previous one drains. For each packet the packet writer takes its command from
// the queue, reads each raw pixel from memory and then captures it, takes each
// run pixel from the command, and emits output words that carry up to four
// pixels each. No clearing pass is needed after reset.
module tga_rle_row_encoder import tga_pkg::*; #(
    parameter int MAX_PACKET = 128
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // red, green, blue, alpha
    input  logic         s_tlast,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_wr_data,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // header_byte, pixel_count, pixel_word_0..3
    output logic         m_tlast,
    output logic [1:0]   m_tuser    // header_valid, end_of_row
);

    localparam int RAW = $clog2(MAX_PACKET) + 1;

    logic           room2, push0, push1, q_valid, pop;
    cmd_t           cmd0, cmd1, q_cmd;
    rel_t           rel;
    logic           ram_we, ram_re;
    logic [RAW-1:0] ram_waddr, ram_raddr;
    logic [31:0]    ram_wdata, ram_rdata;

    tga_front #(.MAX_PACKET(MAX_PACKET)) u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
        .cfg_wr_en, .cfg_wr_data, .room2, .rel, .push0, .push1, .cmd0, .cmd1,
        .ram_we, .ram_waddr, .ram_wdata
    );

    tga_cmd_fifo u_fifo (
        .aclk, .aresetn, .push0, .push1, .cmd0, .cmd1, .room2, .q_valid,
        .q_cmd, .pop
    );

    tga_ram #(.WIDTH(PIX_W), .DEPTH(2 << $clog2(MAX_PACKET))) u_ram (
        .aclk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .re(ram_re), .raddr(ram_raddr), .rdata(ram_rdata)
    );

    tga_back #(.MAX_PACKET(MAX_PACKET)) u_back (
        .aclk, .aresetn, .q_valid, .q_cmd, .pop, .ram_re, .ram_raddr,
        .ram_rdata, .rel, .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser
    );

endmodule

// ===== hw/rtl/tga_ram.sv =====
// Generic simple dual-port RAM with registered read.
module tga_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/tga_cmd_fifo.sv =====
// Packet command queue between the classifier and the packet writer.
module tga_cmd_fifo import tga_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push0,
    input  logic push1,
    input  cmd_t cmd0,
    input  cmd_t cmd1,
    output logic room2,
    output logic q_valid,
    output cmd_t q_cmd,
    input  logic pop
);

    cmd_t            mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [Q_AW:0]   cnt_reg, cnt_next;
    logic [Q_AW-1:0] wp1;

    assign wp1 = wp_reg + 1'b1;

    always_comb begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push0 && push1) begin
            wp_next  = wp_reg + 2'd2;
            cnt_next = cnt_next + 2'd2;
        end else if (push0) begin
            wp_next  = wp1;
            cnt_next = cnt_next + 1'b1;
        end
        if (pop) begin
            rp_next  = rp_reg + 1'b1;
            cnt_next = cnt_next - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (push0) begin
            mem_reg[wp_reg] <= cmd0;
        end
        if (push0 && push1) begin
            mem_reg[wp1] <= cmd1;
        end
    end

    assign room2   = cnt_reg <= (Q_AW + 1)'(Q_DEPTH - 2);
    assign q_valid = cnt_reg != '0;
    assign q_cmd   = mem_reg[rp_reg];

endmodule

// ===== hw/rtl/tga_front.sv =====
// Pixel classifier: accepts pixels, forms packets, fills the raw pixel store.
module tga_front import tga_pkg::*; #(
    parameter int MAX_PACKET = 128
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,
    input  logic                          s_tlast,
    input  logic                          cfg_wr_en,
    input  logic [2:0]                    cfg_wr_data,
    input  logic                          room2,
    input  rel_t                          rel,
    output logic                          push0,
    output logic                          push1,
    output cmd_t                          cmd0,
    output cmd_t                          cmd1,
    output logic                          ram_we,
    output logic [$clog2(MAX_PACKET):0]   ram_waddr,
    output logic [PIX_W-1:0]              ram_wdata
);

    localparam int AW = $clog2(MAX_PACKET);
    localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_PACKET);
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_ONE  = 2'd1;
    localparam logic [1:0] MODE_RUN  = 2'd2;
    localparam logic [1:0] MODE_RAW  = 2'd3;

    logic [1:0]       mode_reg, mode_next;
    logic [PIX_W-1:0] look_reg, look_next;
    logic [PIX_W-1:0] runp_reg, runp_next;
    logic [CNT_W-1:0] runc_reg, runc_next;
    logic [CNT_W-1:0] rawc_reg, rawc_next;
    logic             bank_reg, bank_next;
    logic [1:0]       busy_reg, busy_next;
    logic [2:0]       bpp_reg;
    logic [PIX_W-1:0] pix;
    logic             fire;
    logic [1:0]       n;

    function automatic cmd_t mk_run(logic [CNT_W-1:0] c, logic [PIX_W-1:0] px);
        cmd_t x;
        x.hdr      = RUN_FLAG | {1'b0, 7'(c - 1'b1)};
        x.n_ram    = '0;
        x.bank     = 1'b0;
        x.tail     = 1'b1;
        x.tail_pix = px;
        x.eor      = 1'b0;
        return x;
    endfunction

    function automatic cmd_t mk_raw(logic [CNT_W-1:0] c, logic b, logic t,
                                    logic [PIX_W-1:0] px);
        cmd_t x;
        x.hdr      = {1'b0, 7'(c + CNT_W'(t) - 1'b1)};
        x.n_ram    = c;
        x.bank     = b;
        x.tail     = t;
        x.tail_pix = px;
        x.eor      = 1'b0;
        return x;
    endfunction

    assign s_tready = room2 && !busy_reg[bank_reg];
    assign fire     = s_tvalid && s_tready;
    assign pix      = {(bpp_reg > 3'd3) ? s_tdata[31:24] : 8'h00,
                       s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};

    always_comb begin
        cmd_t x;
        x         = '0;
        mode_next = mode_reg;
        look_next = look_reg;
        runp_next = runp_reg;
        runc_next = runc_reg;
        rawc_next = rawc_reg;
        bank_next = bank_reg;
        busy_next = busy_reg;
        if (rel.valid) begin
            busy_next[rel.bank] = 1'b0;
        end
        n         = 2'd0;
        cmd0      = '0;
        cmd1      = '0;
        ram_we    = 1'b0;
        ram_waddr = {bank_reg, rawc_reg[AW-1:0]};
        ram_wdata = look_reg;
        if (fire) begin
            unique case (mode_reg)
                MODE_IDLE: begin
                    look_next = pix;
                    mode_next = MODE_ONE;
                end
                MODE_ONE: begin
                    if (look_reg == pix) begin
                        runp_next = look_reg;
                        runc_next = CNT_W'(2);
                        mode_next = MODE_RUN;
                        if (runc_next >= MAXC) begin
                            x = mk_run(runc_next, runp_next);
                            if (n == 2'd0) cmd0 = x; else cmd1 = x;
                            n = n + 2'd1;
                            runc_next = '0;
                            mode_next = MODE_IDLE;
                        end
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = {bank_reg, {AW{1'b0}}};
                        rawc_next = CNT_W'(1);
                        look_next = pix;
                        mode_next = MODE_RAW;
                    end
                end
                MODE_RUN: begin
                    if (pix == runp_reg) begin
                        runc_next = runc_reg + 1'b1;
                        if (runc_next >= MAXC) begin
                            x = mk_run(runc_next, runp_reg);
                            if (n == 2'd0) cmd0 = x; else cmd1 = x;
                            n = n + 2'd1;
                            runc_next = '0;
                            mode_next = MODE_IDLE;
                        end
                    end else begin
                        x = mk_run(runc_reg, runp_reg);
                        if (n == 2'd0) cmd0 = x; else cmd1 = x;
                        n = n + 2'd1;
                        runc_next = '0;
                        look_next = pix;
                        mode_next = MODE_ONE;
                    end
                end
                MODE_RAW: begin
                    if (look_reg == pix) begin
                        x = mk_raw(rawc_reg, bank_reg, 1'b0, look_reg);
                        if (n == 2'd0) cmd0 = x; else cmd1 = x;
                        n = n + 2'd1;
                        busy_next[bank_reg] = 1'b1;
                        bank_next = !bank_reg;
                        rawc_next = '0;
                        runp_next = look_reg;
                        runc_next = CNT_W'(2);
                        mode_next = MODE_RUN;
                        if (runc_next >= MAXC) begin
                            x = mk_run(runc_next, runp_next);
                            if (n == 2'd0) cmd0 = x; else cmd1 = x;
                            n = n + 2'd1;
                            runc_next = '0;
                            mode_next = MODE_IDLE;
                        end
                    end else begin
                        ram_we    = 1'b1;
                        rawc_next = rawc_reg + 1'b1;
                        look_next = pix;
                        if (rawc_next >= MAXC) begin
                            x = mk_raw(rawc_next, bank_reg, 1'b0, look_reg);
                            if (n == 2'd0) cmd0 = x; else cmd1 = x;
                            n = n + 2'd1;
                            busy_next[bank_reg] = 1'b1;
                            bank_next = !bank_reg;
                            rawc_next = '0;
                            mode_next = MODE_ONE;
                        end
                    end
                end
                default: begin
                    mode_next = MODE_IDLE;
                end
            endcase
            if (s_tlast) begin
                unique case (mode_next)
                    MODE_ONE: begin
                        x = mk_raw('0, bank_next, 1'b1, look_next);
                        if (n == 2'd0) cmd0 = x; else cmd1 = x;
                        n = n + 2'd1;
                    end
                    MODE_RUN: begin
                        x = mk_run(runc_next, runp_next);
                        if (n == 2'd0) cmd0 = x; else cmd1 = x;
                        n = n + 2'd1;
                    end
                    MODE_RAW: begin
                        x = mk_raw(rawc_next, bank_next, 1'b1, look_next);
                        if (n == 2'd0) cmd0 = x; else cmd1 = x;
                        n = n + 2'd1;
                        busy_next[bank_next] = 1'b1;
                        bank_next = !bank_next;
                    end
                    default: begin
                    end
                endcase
                if (n == 2'd2) begin
                    cmd1.eor = 1'b1;
                end else begin
                    cmd0.eor = 1'b1;
                end
                mode_next = MODE_IDLE;
                rawc_next = '0;
                runc_next = '0;
            end
        end
        push0 = n != 2'd0;
        push1 = n == 2'd2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            look_reg <= '0;
            runp_reg <= '0;
            runc_reg <= '0;
            rawc_reg <= '0;
            bank_reg <= 1'b0;
            busy_reg <= '0;
            bpp_reg  <= 3'd4;
        end else begin
            mode_reg <= mode_next;
            look_reg <= look_next;
            runp_reg <= runp_next;
            runc_reg <= runc_next;
            rawc_reg <= rawc_next;
            bank_reg <= bank_next;
            busy_reg <= busy_next;
            if (cfg_wr_en) begin
                bpp_reg <= cfg_wr_data;
            end
        end
    end

endmodule

// ===== hw/rtl/tga_back.sv =====
// Packet writer: turns packet commands into output words of up to four pixels.
module tga_back import tga_pkg::*; #(
    parameter int MAX_PACKET = 128
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    input  cmd_t                        q_cmd,
    output logic                        pop,
    output logic                        ram_re,
    output logic [$clog2(MAX_PACKET):0] ram_raddr,
    input  logic [PIX_W-1:0]            ram_rdata,
    output rel_t                        rel,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [143:0]                m_tdata,
    output logic                        m_tlast,
    output logic [1:0]                  m_tuser
);

    localparam int AW = $clog2(MAX_PACKET);
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]       st_reg, st_next;
    cmd_t             cmd_reg, cmd_next;
    logic [CNT_W:0]   pos_reg, pos_next;
    logic [1:0]       slot_reg, slot_next;
    logic [PIX_W-1:0] wd_reg [4];
    logic [PIX_W-1:0] wd_next [4];
    logic             first_reg, first_next;
    logic             ov_reg, ov_next;
    logic             ohv_reg, ohv_next;
    logic [7:0]       ohdr_reg, ohdr_next;
    logic [2:0]       ocnt_reg, ocnt_next;
    logic [PIX_W-1:0] ow_reg [4];
    logic [PIX_W-1:0] ow_next [4];
    logic             oeop_reg, oeop_next;
    logic             oeor_reg, oeor_next;
    logic [CNT_W:0]   ntot;
    logic [CNT_W:0]   pos1;
    logic             eop;

    assign ntot = {1'b0, cmd_reg.n_ram} + (CNT_W + 1)'(cmd_reg.tail);
    assign pos1 = pos_reg + 1'b1;
    assign eop  = pos_reg == ntot;

    always_comb begin
        st_next    = st_reg;
        cmd_next   = cmd_reg;
        pos_next   = pos_reg;
        slot_next  = slot_reg;
        wd_next    = wd_reg;
        first_next = first_reg;
        ov_next    = ov_reg;
        ohv_next   = ohv_reg;
        ohdr_next  = ohdr_reg;
        ocnt_next  = ocnt_reg;
        ow_next    = ow_reg;
        oeop_next  = oeop_reg;
        oeor_next  = oeor_reg;
        pop        = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = {cmd_reg.bank, pos_reg[AW-1:0]};
        rel        = '0;
        if (ov_reg && m_tready) begin
            ov_next = 1'b0;
        end
        unique case (st_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    pop        = 1'b1;
                    cmd_next   = q_cmd;
                    pos_next   = '0;
                    slot_next  = '0;
                    first_next = 1'b1;
                    wd_next    = '{default: '0};
                    st_next    = ST_FETCH;
                end
            end
            ST_FETCH, ST_WAIT: begin
                if (st_reg == ST_FETCH && pos_reg < {1'b0, cmd_reg.n_ram}) begin
                    ram_re  = 1'b1;
                    st_next = ST_WAIT;
                end else begin
                    wd_next[slot_reg] = (st_reg == ST_WAIT) ? ram_rdata
                                                            : cmd_reg.tail_pix;
                    pos_next = pos1;
                    if (slot_reg == 2'd3 || pos1 == ntot) begin
                        st_next = ST_EMIT;
                    end else begin
                        slot_next = slot_reg + 1'b1;
                        st_next   = ST_FETCH;
                    end
                end
            end
            ST_EMIT: begin
                if (!ov_reg || m_tready) begin
                    ov_next   = 1'b1;
                    ohv_next  = first_reg;
                    ohdr_next = first_reg ? cmd_reg.hdr : 8'h00;
                    ocnt_next = {1'b0, slot_reg} + 3'd1;
                    ow_next   = wd_reg;
                    oeop_next = eop;
                    oeor_next = eop && cmd_reg.eor;
                    if (eop) begin
                        rel.valid = cmd_reg.n_ram != '0;
                        rel.bank  = cmd_reg.bank;
                        st_next   = ST_IDLE;
                    end else begin
                        slot_next  = '0;
                        first_next = 1'b0;
                        wd_next    = '{default: '0};
                        st_next    = ST_FETCH;
                    end
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            ov_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            ov_reg <= ov_next;
        end
        cmd_reg   <= cmd_next;
        pos_reg   <= pos_next;
        slot_reg  <= slot_next;
        wd_reg    <= wd_next;
        first_reg <= first_next;
        ohv_reg   <= ohv_next;
        ohdr_reg  <= ohdr_next;
        ocnt_reg  <= ocnt_next;
        ow_reg    <= ow_next;
        oeop_reg  <= oeop_next;
        oeor_reg  <= oeor_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {5'd0, ow_reg[3], ow_reg[2], ow_reg[1], ow_reg[0], ocnt_reg, ohdr_reg};
    assign m_tlast  = oeop_reg;
    assign m_tuser  = {oeor_reg, ohv_reg};

    a_eor_eop: assert property (@(posedge aclk) disable iff (!aresetn)
        ov_reg && oeor_reg |-> oeop_reg)
        else $error("Row end outside a packet end.");
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        ov_reg |-> (ocnt_reg != 3'd0 && ocnt_reg <= 3'd4))
        else $error("Pixel count out of range.");
    a_run: assert property (@(posedge aclk) disable iff (!aresetn)
        ov_reg && ohv_reg && ohdr_reg[7] |-> (ocnt_reg == 3'd1 && oeop_reg))
        else $error("Run packet with more than one word.");

endmodule

// ===== sim/tb_tga_rle_row_encoder.sv =====
// Self-checking testbench for the Targa run-length row encoder.
`timescale 1ns / 1ps

module tb_tga_rle_row_encoder;
    import tga_pkg::*;

    localparam int PKT_MAX = 128;
    localparam int DRAIN_CYCLES = 600;
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ONE  = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_RAW  = 2'd3;

    typedef struct {
        logic [31:0] data;
        logic        last;
    } pixel_word_t;

    typedef struct {
        logic        hdr_valid;
        logic [7:0]  hdr;
        logic [2:0]  count;
        logic [31:0] px [4];
        logic        eop;
        logic        eor;
    } packet_word_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [31:0]  s_tdata;
    logic         s_tlast;
    logic         cfg_wr_en;
    logic [2:0]   cfg_wr_data;
    logic         m_tvalid;
    logic         m_tready;
    logic [143:0] m_tdata;
    logic         m_tlast;
    logic [1:0]   m_tuser;

    pixel_word_t  pending_pixels[$];
    packet_word_t expected_words[$];
    int           error_count;
    int           send_idle_pct;
    int           recv_stall_pct;
    bit           send_hold;
    logic         s_taken;

    logic [31:0]  raw_buf [PKT_MAX];
    int           raw_len;
    logic [31:0]  run_px;
    int           run_len;
    logic [31:0]  held_px;
    logic [1:0]   enc_state;
    logic [2:0]   bpp;

    tga_rle_row_encoder i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want,
                 $realtime);
        error_count++;
    endtask

    task automatic queue_packet(input logic [7:0] hdr, input logic [31:0] pix [PKT_MAX],
                                input int npix);
        packet_word_t w;
        int i;
        int k;
        i = 0;
        while (i < npix) begin
            k = (npix - i > 4) ? 4 : npix - i;
            w.hdr_valid = (i == 0);
            w.hdr = (i == 0) ? hdr : 8'h00;
            w.count = 3'(k);
            for (int j = 0; j < 4; j++) begin
                w.px[j] = (j < k) ? pix[i + j] : 32'h0;
            end
            i += k;
            w.eop = (i >= npix);
            w.eor = 1'b0;
            expected_words.push_back(w);
        end
    endtask

    task automatic flush_run();
        logic [31:0] one [PKT_MAX];
        one[0] = run_px;
        queue_packet(RUN_FLAG | 8'((run_len - 1) & 8'h7f), one, 1);
        run_len = 0;
        enc_state = ST_IDLE;
    endtask

    task automatic flush_raw();
        queue_packet(8'((raw_len - 1) & 8'h7f), raw_buf, raw_len);
        raw_len = 0;
        enc_state = ST_IDLE;
    endtask

    task automatic start_run(input logic [31:0] px);
        run_px = px;
        run_len = 2;
        enc_state = ST_RUN;
        if (run_len >= PKT_MAX) flush_run();
    endtask

    task automatic encode_pixel(input logic [31:0] word, input logic last);
        logic [31:0] px;
        int n_prior;
        n_prior = expected_words.size();
        px = {8'h00, word[7:0], word[15:8], word[23:16]};
        if (bpp > 3) px[31:24] = word[31:24];
        case (enc_state)
            ST_IDLE: begin
                held_px = px;
                enc_state = ST_ONE;
            end
            ST_ONE: begin
                if (held_px == px) begin
                    start_run(held_px);
                end else begin
                    raw_buf[0] = held_px;
                    raw_len = 1;
                    held_px = px;
                    enc_state = ST_RAW;
                end
            end
            ST_RUN: begin
                if (px == run_px) begin
                    run_len++;
                    if (run_len >= PKT_MAX) flush_run();
                end else begin
                    flush_run();
                    held_px = px;
                    enc_state = ST_ONE;
                end
            end
            default: begin
                if (held_px == px) begin
                    flush_raw();
                    start_run(held_px);
                end else begin
                    raw_buf[raw_len] = held_px;
                    raw_len++;
                    held_px = px;
                    if (raw_len >= PKT_MAX) begin
                        flush_raw();
                        enc_state = ST_ONE;
                    end
                end
            end
        endcase
        if (last) begin
            if (enc_state == ST_ONE) begin
                raw_buf[0] = held_px;
                raw_len = 1;
                flush_raw();
            end else if (enc_state == ST_RUN) begin
                flush_run();
            end else if (enc_state == ST_RAW) begin
                raw_buf[raw_len] = held_px;
                raw_len++;
                flush_raw();
            end
            enc_state = ST_IDLE;
            raw_len = 0;
            run_len = 0;
            if (expected_words.size() > n_prior) begin
                expected_words[expected_words.size() - 1].eor = 1'b1;
            end
        end
    endtask

    // Input monitor feeds the predictor; output monitor checks the oldest expectation.
    always @(posedge aclk) begin
        s_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && cfg_wr_en) bpp <= cfg_wr_data;
        if (aresetn && s_tvalid && s_tready) encode_pixel(s_tdata, s_tlast);
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", m_tdata[31:0], 32'h0);
            end else begin
                packet_word_t w;
                w = expected_words.pop_front();
                if (m_tuser[0] !== w.hdr_valid)
                    report_mismatch("header_valid", m_tuser[0], w.hdr_valid);
                if (m_tdata[7:0] !== w.hdr)
                    report_mismatch("header_byte", m_tdata[7:0], w.hdr);
                if (m_tdata[10:8] !== w.count)
                    report_mismatch("pixel_count", m_tdata[10:8], w.count);
                for (int j = 0; j < 4; j++) begin
                    if (m_tdata[11 + 32 * j +: 32] !== w.px[j]) begin
                        report_mismatch($sformatf("pixel_word_%0d", j),
                                        m_tdata[11 + 32 * j +: 32], w.px[j]);
                    end
                end
                if (m_tlast !== w.eop)
                    report_mismatch("end_of_packet", m_tlast, w.eop);
                if (m_tuser[1] !== w.eor)
                    report_mismatch("end_of_row", m_tuser[1], w.eor);
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (!send_hold && pending_pixels.size() > 0
                    && $urandom_range(99) >= send_idle_pct) begin
                pixel_word_t p;
                p = pending_pixels.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= p.data;
                s_tlast <= p.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic push_pixel(input logic [31:0] d, input logic last);
        pixel_word_t p;
        p.data = d;
        p.last = last;
        pending_pixels.push_back(p);
    endtask

    task automatic push_run(input logic [31:0] d, input int n, input logic close_row);
        for (int i = 0; i < n; i++) push_pixel(d, close_row && i == n - 1);
    endtask

    task automatic push_raw(input int n, input logic close_row);
        for (int i = 0; i < n; i++) begin
            push_pixel(32'(i * 32'h01010101 + 1), close_row && i == n - 1);
        end
    endtask

    // Rows built from runs and raw stretches, mostly drawn from a small per-row palette with some fully random pixels.
    task automatic push_random_rows(input int target);
        logic [31:0] pal [4];
        int sent;
        int len;
        sent = 0;
        while (sent < target) begin
            for (int i = 0; i < 4; i++) pal[i] = $urandom;
            pal[1] = pal[0] ^ 32'hff000000;
            len = ($urandom_range(19) == 0) ? $urandom_range(140, 300)
                                             : $urandom_range(1, 30);
            for (int i = 0; i < len; i++) begin
                logic [31:0] d;
                case ($urandom_range(3))
                    0: d = $urandom;
                    default: d = pal[$urandom_range(3)];
                endcase
                if (i > 0 && $urandom_range(2) == 0) begin
                    d = pending_pixels[pending_pixels.size() - 1].data;
                end
                push_pixel(d, i == len - 1);
            end
            sent += len;
        end
    endtask

    task automatic settle();
        wait (pending_pixels.size() == 0 && !s_tvalid);
        wait (expected_words.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_bpp(input logic [2:0] v);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        s_taken = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 3'd4;
        m_tready = 1'b0;
        error_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_hold = 1'b0;
        bpp = 3'd4;
        raw_len = 0;
        run_len = 0;
        enc_state = ST_IDLE;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed rows: extremes, single pixel, runs and raw packets at the size limit.
        push_pixel(32'hffffffff, 1'b1);
        push_pixel(32'h00000000, 1'b0);
        push_pixel(32'h00000000, 1'b1);
        push_pixel(32'hffffffff, 1'b0);
        push_pixel(32'h00ffffff, 1'b1);
        push_run(32'h12345678, 129, 1'b1);
        push_raw(129, 1'b1);
        push_raw(3, 1'b0);
        push_run(32'h55aa55aa, 3, 1'b0);
        push_raw(2, 1'b1);
        settle();

        // Alpha ignored: pixels differing only in alpha form a run.
        write_bpp(3'd3);
        push_pixel(32'h11223344, 1'b0);
        push_pixel(32'hff223344, 1'b0);
        push_pixel(32'h00223344, 1'b1);
        send_idle_pct = 58;
        push_random_rows(30);
        settle();

        write_bpp(3'd7);
        recv_stall_pct = 58;
        send_idle_pct = 0;
        push_random_rows(30);
        wait (pending_pixels.size() < 20);
        send_hold = 1'b1;
        wait (!s_tvalid);
        wait (expected_words.size() == 0);
        send_hold = 1'b0;
        settle();

        write_bpp(3'd0);
        send_idle_pct = 32;
        recv_stall_pct = 32;
        push_random_rows(30);
        settle();

        write_bpp(3'd4);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        push_random_rows(30);
        settle();

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
